[sv/bbf_pkg.sv]
// Package with shared constants and types for the box blur filter.
`default_nettype none
package bbf_pkg;
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned PIX_W  = 3 * CHAN_W;
    localparam int unsigned DIM_W  = 10;
    localparam int unsigned WIN_W  = 4;
    localparam int unsigned HEIGHT_LIMIT = 512;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        logic       last;
        chan_t      blue;
        chan_t      green;
        chan_t      red;
    } out_item_t;

    // Per-lane control: which pixels of the fetched row segment are in the window.
    typedef struct packed {
        logic       first;
        logic       row_done;
        logic       pix_done;
    } lane_ctl_t;
endpackage
`default_nettype wire

[sv/bbf_lane.sv]
// One color-channel lane: accumulates window pixels into a sum, one per cycle while add_en is set.
`default_nettype none
module bbf_lane #(
    parameter int unsigned SUM_W = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      clear,
    input  wire logic                      add_en,
    input  wire logic [bbf_pkg::CHAN_W-1:0] pix,
    output logic      [SUM_W-1:0]          sum
);
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    always_comb begin
        sum_next = sum_reg;
        if (clear) begin
            sum_next = '0;
        end else if (add_en) begin
            sum_next = sum_reg + SUM_W'(pix);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;
endmodule
`default_nettype wire

[sv/bbf_divider.sv]
// Restoring divider that turns the three lane sums into saturated averages.
`default_nettype none
module bbf_divider #(
    parameter int unsigned SUM_W = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [3*SUM_W-1:0]    sums,
    input  wire logic [7:0]            divisor,
    output logic                       done,
    output logic [3*bbf_pkg::CHAN_W-1:0] quot
);
    localparam int unsigned CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] num_reg   [3];
    logic [SUM_W-1:0] num_next  [3];
    logic [SUM_W:0]   rem_reg   [3];
    logic [SUM_W:0]   rem_next  [3];
    logic [SUM_W-1:0] q_reg     [3];
    logic [SUM_W-1:0] q_next    [3];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [SUM_W:0]   trial     [3];

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            num_next[k] = num_reg[k];
            rem_next[k] = rem_reg[k];
            q_next[k]   = q_reg[k];
            trial[k]    = {rem_reg[k][SUM_W-1:0], num_reg[k][SUM_W-1]};
        end
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_W);
            for (int k = 0; k < 3; k++) begin
                num_next[k] = sums[k*SUM_W +: SUM_W];
                rem_next[k] = '0;
                q_next[k]   = '0;
            end
        end else if (busy_reg) begin
            for (int k = 0; k < 3; k++) begin
                num_next[k] = {num_reg[k][SUM_W-2:0], 1'b0};
                if (trial[k] >= (SUM_W+1)'(divisor)) begin
                    rem_next[k] = trial[k] - (SUM_W+1)'(divisor);
                    q_next[k]   = {q_reg[k][SUM_W-2:0], 1'b1};
                end else begin
                    rem_next[k] = trial[k];
                    q_next[k]   = {q_reg[k][SUM_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        for (int k = 0; k < 3; k++) begin
            num_reg[k] <= num_next[k];
            rem_reg[k] <= rem_next[k];
            q_reg[k]   <= q_next[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            quot[k*8 +: 8] = (q_reg[k] > SUM_W'(255)) ? 8'hFF : q_reg[k][7:0];
        end
    end

    assign done = done_reg;
endmodule
`default_nettype wire

[sv/box_blur_filter_top.sv]
// Top level of the streaming RGB box blur filter.
`default_nettype none
// Box blur filter: RGB pixels enter in raster order on the s_ channel and the
// blurred frame leaves in raster order on the m_ channel. Each output channel is
// the sum over the window of window_size/2 rows and columns on each side of the
// pixel, clipped to the frame, divided by window_size squared and saturated at
// 255. Pixels are kept in a line store memory of at least (MAX_WINDOW+1) rows,
// rounded up to a power of two. An input item with tuser set is a drain tick
// that flushes one pending output. The block works on one item at a time: an
// item that yields no output only passes through the readiness check; one that
// yields an output is fetched over its window by the single memory read port,
// one pixel per cycle into the three channel lanes, and then divided by the
// bit-serial divider. A finished result waits in the output register, so the
// next item can be taken while it is still unaccepted; only when a second
// result is ready before the first has left does the block stall for it.
// Configuration writes restart the frame and are to be made only while the
// block is idle.
module box_blur_filter_top #(
    parameter int unsigned MAX_WIDTH  = 512,
    parameter int unsigned MAX_WINDOW = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  wire logic        s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // red_out, green_out, blue_out
    output logic             m_tlast    // frame_last
);
    localparam int unsigned ROW_AW = $clog2(MAX_WINDOW + 1);
    localparam int unsigned ROWS   = 1 << ROW_AW;
    localparam int unsigned COL_AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW     = COL_AW + 1;
    localparam int unsigned RW     = 10;
    localparam int unsigned SUM_W  = 8 + 2 * $clog2(MAX_WINDOW + 1);
    localparam int unsigned WW     = $clog2(MAX_WINDOW + 1);

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ACC, S_DRAIN, S_DIV, S_OUT} state_t;

    logic [9:0]  width_reg, height_reg;
    logic [3:0]  window_reg;
    state_t      state_reg;
    logic [RW-1:0] in_row_reg, out_row_reg, x_reg, rhi_reg;
    logic [CW-1:0] in_col_reg, out_col_reg, y_reg, clo_reg, chi_reg;
    logic        full_reg;
    logic [23:0] mem [ROWS * (1 << COL_AW)];
    logic [23:0] rd_reg;
    logic        rd_vld_reg;
    logic        last_reg;
    logic [23:0] res_reg;
    logic        res_last_reg;
    logic        m_vld_reg;

    // Effective sizes.
    logic [CW-1:0] w;
    logic [RW-1:0] h;
    logic [WW-1:0] s;
    logic [WW-1:0] r;
    always_comb begin
        w = (width_reg == 0) ? CW'(1) :
            ((32'(width_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_reg));
        h = (height_reg == 0) ? RW'(1) :
            ((height_reg > 10'(bbf_pkg::HEIGHT_LIMIT)) ? RW'(bbf_pkg::HEIGHT_LIMIT) :
             height_reg);
        s = (window_reg == 0) ? WW'(1) :
            ((32'(window_reg) > MAX_WINDOW) ? WW'(MAX_WINDOW) : WW'(window_reg));
        r = s >> 1;
    end

    logic [7:0] divisor_reg;
    always_ff @(posedge aclk) divisor_reg <= 8'(s) * 8'(s);

    // Readiness check: outputs depend on rhi/chi; compare rows and cols directly.
    logic [RW-1:0] rhi_c;
    logic [CW-1:0] chi_c, clo_c;
    logic [RW-1:0] rlo_c;
    logic          ready_c;
    always_comb begin
        rhi_c = ((out_row_reg + RW'(r)) > (h - 1'b1)) ? h - 1'b1 : out_row_reg + RW'(r);
        chi_c = ((out_col_reg + CW'(r)) > (w - 1'b1)) ? w - 1'b1 : out_col_reg + CW'(r);
        rlo_c = (out_row_reg >= RW'(r)) ? out_row_reg - RW'(r) : '0;
        clo_c = (out_col_reg >= CW'(r)) ? out_col_reg - CW'(r) : '0;
        ready_c = full_reg || (in_row_reg > rhi_c) ||
                  ((in_row_reg == rhi_c) && (in_col_reg > chi_c));
    end

    logic          take;
    logic          is_pix;
    logic          acc_last;
    logic          out_load;
    logic [ROW_AW-1:0] xrow;
    assign take    = s_tvalid && s_tready;
    assign is_pix  = !s_tuser && !full_reg;
    assign xrow    = x_reg[ROW_AW-1:0];
    assign acc_last = (x_reg == rhi_reg) && (y_reg == chi_reg);
    assign s_tready = (state_reg == S_IDLE);
    // The finished result moves into the output register once it is free.
    assign out_load = (state_reg == S_OUT) && (!m_vld_reg || m_tready);

    logic div_start_reg, div_done, first_acc_reg;
    logic [3*SUM_W-1:0] sums;
    logic [23:0] quot;

    always_ff @(posedge aclk) begin
        if (take && is_pix) begin
            mem[{in_row_reg[ROW_AW-1:0], COL_AW'(in_col_reg)}] <= s_tdata;
        end
        rd_reg <= mem[{xrow, COL_AW'(y_reg)}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= 10'd512;
            height_reg    <= 10'd512;
            window_reg    <= 4'd3;
            state_reg     <= S_IDLE;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            full_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            m_vld_reg     <= 1'b0;
            first_acc_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= (state_reg == S_DRAIN);
            first_acc_reg <= (state_reg == S_CHECK) && ready_c;
            if (out_load) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    bbf_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                    bbf_pkg::REG_HEIGHT: height_reg <= cfg_data;
                    bbf_pkg::REG_WINDOW: window_reg <= cfg_data[3:0];
                    default: ;
                endcase
                if (cfg_index <= bbf_pkg::REG_WINDOW) begin
                    in_row_reg  <= '0;
                    in_col_reg  <= '0;
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                    full_reg    <= 1'b0;
                end
            end else begin
                unique case (state_reg)
                    S_IDLE: begin
                        if (take) begin
                            if (is_pix) begin
                                if (in_col_reg + 1'b1 >= w) begin
                                    in_col_reg <= '0;
                                    if (in_row_reg + 1'b1 >= h) begin
                                        in_row_reg <= '0;
                                        full_reg   <= 1'b1;
                                    end else begin
                                        in_row_reg <= in_row_reg + 1'b1;
                                    end
                                end else begin
                                    in_col_reg <= in_col_reg + 1'b1;
                                end
                            end
                            state_reg <= S_CHECK;
                        end
                    end
                    S_CHECK: begin
                        if (ready_c) begin
                            x_reg    <= rlo_c;
                            y_reg    <= clo_c;
                            clo_reg  <= clo_c;
                            chi_reg  <= chi_c;
                            rhi_reg  <= rhi_c;
                            last_reg <= (out_row_reg == h - 1'b1) &&
                                        (out_col_reg == w - 1'b1);
                            state_reg <= S_ACC;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_ACC: begin
                        rd_vld_reg <= 1'b1;
                        if (acc_last) begin
                            state_reg <= S_DRAIN;
                        end else if (y_reg == chi_reg) begin
                            y_reg <= clo_reg;
                            x_reg <= x_reg + 1'b1;
                        end else begin
                            y_reg <= y_reg + 1'b1;
                        end
                    end
                    S_DRAIN: begin
                        rd_vld_reg <= 1'b0;
                        state_reg  <= S_DIV;
                    end
                    S_DIV: begin
                        if (div_done) begin
                            state_reg <= S_OUT;
                        end
                    end
                    S_OUT: begin
                        // The divider holds its quotient until the next start.
                        if (out_load) begin
                            res_reg      <= quot;
                            res_last_reg <= last_reg;
                            state_reg    <= S_IDLE;
                            if (last_reg) begin
                                in_row_reg  <= '0;
                                in_col_reg  <= '0;
                                out_row_reg <= '0;
                                out_col_reg <= '0;
                                full_reg    <= 1'b0;
                            end else if (out_col_reg + 1'b1 >= w) begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_reg + 1'b1;
                            end else begin
                                out_col_reg <= out_col_reg + 1'b1;
                            end
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    // Three channel lanes share the fetched pixel; the divider merges them.
    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            bbf_lane #(.SUM_W(SUM_W)) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .clear   (first_acc_reg),
                .add_en  (rd_vld_reg),
                .pix     (rd_reg[(2-g)*8 +: 8]),
                .sum     (sums[g*SUM_W +: SUM_W])
            );
        end
    endgenerate

    bbf_divider #(.SUM_W(SUM_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .sums    (sums),
        .divisor (divisor_reg),
        .done    (div_done),
        .quot    (quot)
    );

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {res_reg[7:0], res_reg[15:8], res_reg[23:16]};
    assign m_tlast  = res_last_reg;

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input taken while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped");
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while waiting");
    a_div_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_done && state_reg == S_DIV) |=> (state_reg == S_OUT))
        else $error("divider result lost");
endmodule
`default_nettype wire

[tb/sv/box_blur_filter_top_test.sv]
// Self-checking testbench for the streaming RGB box blur filter.
`default_nettype none
module box_blur_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Kinds of input item carried on s_tuser.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;
    localparam int STORE_ROWS  = 16;
    localparam int MAX_COLS    = 512;
    // Longest time one item can keep the block busy, with margin.
    localparam int SETTLE_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    box_blur_filter_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Blurred pixels still owed by the block, oldest first.
    bbf_pkg::out_item_t blurred_q[$];
    int        fail_count;

    // Predictor state: a copy of the frame geometry, the stored rows and
    // the input and output raster positions.
    logic [9:0]  width_reg, height_reg;
    logic [3:0]  window_reg;
    logic [23:0] row_store [STORE_ROWS][MAX_COLS];
    int unsigned in_row, in_col, out_row, out_col;
    bit          frame_in_done;

    // Sender pacing: items go out in bursts, separated by random gaps unless the sender is steady.
    int  burst_left;
    bit  sender_steady;
    // Receiver stall pattern selector.
    int  stall_mode;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("box_blur_filter_top regression: fail");
        $finish;
    end

    function automatic int unsigned cur_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_COLS) return MAX_COLS;
        return width_reg;
    endfunction

    function automatic int unsigned cur_height();
        if (height_reg == 0) return 1;
        if (height_reg > bbf_pkg::HEIGHT_LIMIT) return bbf_pkg::HEIGHT_LIMIT;
        return height_reg;
    endfunction

    function automatic int unsigned cur_window();
        if (window_reg == 0) return 1;
        return window_reg;
    endfunction

    function automatic void restart_raster();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        frame_in_done = 0;
    endfunction

    function automatic logic [7:0] clip_chan(int unsigned sum, int unsigned div);
        int unsigned q;
        q = sum / div;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Advances the blur predictor by one accepted item and queues the
    // blurred pixel it releases, if any.
    function automatic void blur_accept(logic action, logic [23:0] pix);
        int unsigned w, h, s, rad, have, need, rlo, rhi, clo, chi;
        int unsigned sr, sg, sb;
        logic [23:0] p;
        bbf_pkg::out_item_t o;
        w = cur_width();
        h = cur_height();
        s = cur_window();
        rad = s / 2;
        sr = 0;
        sg = 0;
        sb = 0;
        // A pixel arriving while the previous frame is still draining is dropped.
        if (action == ACT_PIXEL && !frame_in_done) begin
            row_store[in_row % STORE_ROWS][in_col] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) begin
                    in_row = 0;
                    frame_in_done = 1;
                end
            end
        end
        have = frame_in_done ? h * w : in_row * w + in_col;
        rhi = (out_row + rad > h - 1) ? h - 1 : out_row + rad;
        chi = (out_col + rad > w - 1) ? w - 1 : out_col + rad;
        need = rhi * w + chi;
        if (have <= need) return;
        rlo = (out_row >= rad) ? out_row - rad : 0;
        clo = (out_col >= rad) ? out_col - rad : 0;
        for (int unsigned x = rlo; x <= rhi; x++) begin
            for (int unsigned y = clo; y <= chi; y++) begin
                p = row_store[x % STORE_ROWS][y];
                sr += p[7:0];
                sg += p[15:8];
                sb += p[23:16];
            end
        end
        o.red   = clip_chan(sr, s * s);
        o.green = clip_chan(sg, s * s);
        o.blue  = clip_chan(sb, s * s);
        o.last  = (out_row == h - 1) && (out_col == w - 1);
        blurred_q.push_back(o);
        if (o.last) begin
            restart_raster();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    // Waits until every owed pixel has come out and the block has had time
    // to finish any item that releases nothing.
    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [9:0] val);
        wait_quiet();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            bbf_pkg::REG_WIDTH:  width_reg  = val;
            bbf_pkg::REG_HEIGHT: height_reg = val;
            bbf_pkg::REG_WINDOW: window_reg = val[3:0];
            default: ;
        endcase
        restart_raster();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(int w, int h, int win);
        write_reg(bbf_pkg::REG_WIDTH, 10'(w));
        write_reg(bbf_pkg::REG_HEIGHT, 10'(h));
        write_reg(bbf_pkg::REG_WINDOW, 10'(win));
    endtask

    // Sends one item and returns after the block has taken it. Valid stays
    // high when the next item follows without a gap.
    task automatic send_item(logic action, logic [23:0] pix);
        @(negedge aclk);
        if (burst_left == 0) begin
            if (!sender_steady) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        blur_accept(action, pix);
    endtask

    // Sends a whole frame of random pixels with a little noise, then drains it.
    task automatic run_frame(int noise_pct);
        int n;
        n = cur_width() * cur_height();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(ACT_DRAIN, 24'($urandom));
            send_item(ACT_PIXEL, 24'($urandom));
        end
        while (frame_in_done) begin
            // Pixels sent now are dropped and act as drain ticks.
            if ($urandom_range(0, 99) < noise_pct) send_item(ACT_PIXEL, 24'($urandom));
            else send_item(ACT_DRAIN, 24'($urandom));
        end
    endtask

    task automatic test_directed();
        logic [23:0] pat [12];
        pat = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hAA55AA,
                24'h55AA55, 24'hFFFFFF, 24'h000000, 24'h808080, 24'h7F7F7F, 24'h010101};
        set_geometry(4, 3, 3);
        // A drain tick with nothing ready releases nothing.
        send_item(ACT_DRAIN, 24'hFFFFFF);
        foreach (pat[i]) send_item(ACT_PIXEL, pat[i]);
        // A pixel after a complete frame is dropped while outputs are pending.
        send_item(ACT_PIXEL, 24'hFFFFFF);
        while (frame_in_done) send_item(ACT_DRAIN, 24'h0);
        send_item(ACT_DRAIN, 24'h0);
    endtask

    task automatic test_window_extremes();
        // Window of one passes pixels through; an all-white frame exercises
        // the largest sums.
        set_geometry(5, 4, 1);
        run_frame(0);
        write_reg(bbf_pkg::REG_WINDOW, 10'd15);
        for (int i = 0; i < 20; i++) send_item(ACT_PIXEL, 24'hFFFFFF);
        while (frame_in_done) send_item(ACT_DRAIN, 24'h0);
        write_reg(bbf_pkg::REG_WINDOW, 10'd0);
        run_frame(10);
        write_reg(bbf_pkg::REG_WINDOW, 10'd2);
        run_frame(10);
    endtask

    task automatic test_size_extremes();
        set_geometry(1, 1, 3);
        run_frame(0);
        set_geometry(0, 0, 3);
        run_frame(0);
        // Out-of-range width clips to the widest row.
        set_geometry(1023, 1, 5);
        run_frame(5);
        // Out-of-range height clips to the tallest frame.
        set_geometry(1, 1023, 1);
        run_frame(5);
    endtask

    task automatic test_random_frames();
        int sent_goal, w, h, n;
        sent_goal = 150;
        while (sent_goal > 0) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            set_geometry(w, h, $urandom_range(0, 15));
            n = cur_width() * cur_height();
            if ($urandom_range(0, 7) == 0) begin
                // Abandon the frame partway; the next register write restarts it.
                for (int i = 0; i < n / 2; i++) send_item(ACT_PIXEL, 24'($urandom));
            end else begin
                run_frame(8);
            end
            sent_goal -= n;
        end
        sender_steady = 0;
    endtask

    // Receiver stall pattern: the mode changes periodically to a random choice.
    initial begin
        int cyc;
        m_tready = 1'b0;
        cyc = 0;
        stall_mode = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                2: m_tready <= (cyc % 4 == 0);
                default: m_tready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // Result checker: every accepted pixel is matched to the oldest expectation.
    initial begin
        bbf_pkg::out_item_t exp_px;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (blurred_q.size() == 0) begin
                    $error("unexpected output pixel %h last %b", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    exp_px = blurred_q.pop_front();
                    if (m_tdata[7:0] !== exp_px.red) begin
                        $error("red_out: expected %0d, got %0d", exp_px.red, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[15:8] !== exp_px.green) begin
                        $error("green_out: expected %0d, got %0d",
                               exp_px.green, m_tdata[15:8]);
                        fail_count++;
                    end
                    if (m_tdata[23:16] !== exp_px.blue) begin
                        $error("blue_out: expected %0d, got %0d",
                               exp_px.blue, m_tdata[23:16]);
                        fail_count++;
                    end
                    if (m_tlast !== exp_px.last) begin
                        $error("frame_last: expected %0d, got %0d", exp_px.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        fail_count = 0;
        burst_left = 0;
        sender_steady = 0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = bbf_pkg::REG_WIDTH;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tuser   = ACT_PIXEL;
        s_tdata   = '0;
        width_reg  = 10'd512;
        height_reg = 10'd512;
        window_reg = 4'd3;
        restart_raster();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_window_extremes();
        test_size_extremes();
        test_random_frames();

        wait_quiet();
        if (fail_count == 0) begin
            $display("box_blur_filter_top regression: pass");
        end else begin
            $display("box_blur_filter_top regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
